@@ rtl/sine_taylor_series_defines.svh @@
// ----------------------------------------------------------------------------
// sine_taylor_series_defines
// Assertion macros shared by the checker files of the sine block.
// ----------------------------------------------------------------------------
`ifndef SINE_TAYLOR_SERIES_DEFINES_SVH
`define SINE_TAYLOR_SERIES_DEFINES_SVH

// clocked on clk, off while rst_n is low
`define STSIN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked on clk, also checked through reset
`define STSIN_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/stsin_pkg.sv @@
// ----------------------------------------------------------------------------
// stsin_pkg
// Fixed-point formats and constants of the Taylor series sine block.
// ----------------------------------------------------------------------------
package stsin_pkg;

  localparam int FRAC_W      = 40;               // Q.40 fraction bits
  localparam int RED_SHIFT   = 16;               // Q8.24 angle -> Q.40
  localparam int TP_W        = 43;
  localparam logic [TP_W-1:0] TWO_PI_Q40 = 43'h6487ED5110B;

  localparam int TERM_W      = 48;               // term magnitude
  localparam int X2_W        = 46;               // x*x, x below 2*pi
  localparam int ACC_W       = 52;               // signed Q.40 sum

  localparam int MUL_HALF    = 24;
  localparam int MUL_W       = 2 * MUL_HALF;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int MRES_W      = PROD_W - FRAC_W;  // rounded product

  localparam int DIG_W       = 4;                // radix-16 divider
  localparam int DIVN_W      = 56;
  localparam int DIV_DIGITS  = DIVN_W / DIG_W;
  localparam int D_W         = 12;               // 2i(2i+1), i below 32

  localparam int THR_W       = 40;
  localparam logic [THR_W-1:0] THR_RESET = 40'd5497558;

  localparam int SINE_W      = 32;
  localparam int ROUND_SHIFT = 10;               // Q.40 -> Q.30
  localparam int QR_W        = ACC_W - ROUND_SHIFT + 1;
  localparam logic [SINE_W-1:0] SINE_MAX = 32'h7FFFFFFF;
  localparam logic [SINE_W-1:0] SINE_MIN = 32'h80000000;

endpackage

@@ rtl/stsin_mul.sv @@
// ----------------------------------------------------------------------------
// stsin_mul
// Shared 48x48 multiplier built on one 24x24 product, four partial
// products summed over cycles, result rounded to nearest at 2^-40.
// ----------------------------------------------------------------------------
module stsin_mul import stsin_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic              done,
  output logic [MRES_W-1:0] res
);

  localparam int N_PP   = 4;
  localparam int STEP_W = $clog2(N_PP + 1);

  logic [MUL_W-1:0]    a_r, b_r;
  logic [MUL_W-1:0]    pp_r;
  logic [1:0]          sh_r;
  logic [PROD_W-1:0]   prod_r;
  logic [STEP_W-1:0]   step_r;
  logic                run_r, done_r;

  logic [MUL_HALF-1:0] a_part, b_part;
  logic [MUL_W-1:0]    pp_nxt;
  logic [PROD_W-1:0]   prod_nxt;

  always_comb begin
    a_part   = step_r[1] ? a_r[MUL_W-1:MUL_HALF] : a_r[MUL_HALF-1:0];
    b_part   = step_r[0] ? b_r[MUL_W-1:MUL_HALF] : b_r[MUL_HALF-1:0];
    pp_nxt   = a_part * b_part;
    prod_nxt = prod_r + (PROD_W'(pp_r) << (MUL_HALF * sh_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(N_PP)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r    <= a;
      b_r    <= b;
      prod_r <= '0;
    end else if (run_r) begin
      if (step_r != STEP_W'(N_PP)) begin
        pp_r <= pp_nxt;
        sh_r <= {1'b0, step_r[1]} + {1'b0, step_r[0]};
      end
      if (step_r != '0) begin
        prod_r <= prod_nxt;
      end
    end
  end

  assign done = done_r;
  assign res  = prod_r[PROD_W-1:FRAC_W] + MRES_W'(prod_r[FRAC_W-1]);

endmodule

@@ rtl/stsin_div.sv @@
// ----------------------------------------------------------------------------
// stsin_div
// Radix-16 divider by a 12-bit divisor, one quotient digit per cycle.
// ----------------------------------------------------------------------------
module stsin_div import stsin_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVN_W-1:0] num,
  input  logic [D_W-1:0]    den,
  output logic              done,
  output logic [DIVN_W-1:0] quo
);

  localparam int CNT_W  = $clog2(DIV_DIGITS + 1);
  localparam int VAL_W  = D_W + DIG_W;
  localparam int N_MULT = 1 << DIG_W;

  logic [DIVN_W-1:0] num_r, quo_r;
  logic [D_W-1:0]    den_r, rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              run_r, done_r;

  logic [VAL_W-1:0]  val;
  logic [VAL_W-1:0]  mult [N_MULT];
  logic [DIG_W-1:0]  digit;
  logic [VAL_W-1:0]  rem_full;

  always_comb begin
    val   = {rem_r, num_r[DIVN_W-1 -: DIG_W]};
    digit = '0;
    for (int j = 0; j < N_MULT; j++) begin
      mult[j] = VAL_W'(j) * VAL_W'(den_r);
    end
    for (int j = 1; j < N_MULT; j++) begin
      if (mult[j] <= val) begin
        digit = DIG_W'(j);
      end
    end
    rem_full = val - mult[digit];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(DIV_DIGITS);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (run_r) begin
      num_r <= num_r << DIG_W;
      rem_r <= rem_full[D_W-1:0];
      quo_r <= {quo_r[DIVN_W-DIG_W-1:0], digit};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

@@ rtl/sine_taylor_series.sv @@
// ----------------------------------------------------------------------------
// sine_taylor_series
// Sine of a Q8.24 angle by a Taylor series, Q2.30 result, built around a
// shared multiplier and a digit divider under a small sequencer.
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  input     in_angle                       start & !busy
//  result    out_sine                       out_valid, one cycle, no stall
//  config    cfg_wdata (term_threshold)     cfg_we
//
//  Reduction mod 2*pi: K steps, one compare and subtract of 2*pi*2^k per
//  cycle, K = ANGLE_WIDTH-26 (one below 27 bits). Then x is squared in the
//  multiplier; each later term is one multiply by x*x and one radix-16
//  divide by 2i(2i+1). Up to MAX_TERMS-1 later terms, fewer once a new
//  term falls below term_threshold; busy is high while a beat is worked on.
//  out_valid pulses in the cycle busy drops; the next start is taken there.
//  rst_n is synchronous; it clears the sequencer and sets term_threshold.
// ----------------------------------------------------------------------------
module sine_taylor_series import stsin_pkg::*; #(
  parameter int MAX_TERMS   = 24,
  parameter int ANGLE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [ANGLE_WIDTH-1:0] in_angle,
  output logic                          out_valid,
  output logic signed [SINE_W-1:0]      out_sine,
  input  logic                          cfg_we,
  input  logic        [THR_W-1:0]       cfg_wdata
);

  localparam int RED_W   = ANGLE_WIDTH + RED_SHIFT;
  localparam int RW      = (RED_W > TP_W) ? RED_W : TP_W;
  localparam int K_STEPS = (RED_W > TP_W) ? (RED_W - TP_W + 1) : 1;
  localparam int RCNT_W  = $clog2(K_STEPS + 1);
  localparam int I_W     = $clog2(MAX_TERMS);
  localparam int DF_W    = 2 * I_W + 2;
  localparam logic [RW-1:0] TP_TOP = RW'(TWO_PI_Q40) << (K_STEPS - 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MOD  = 7'b0000010,
    S_INIT = 7'b0000100,
    S_SQ   = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t                    state_r, state_nxt;
  logic                      xneg_r, xneg_nxt;
  logic [RW-1:0]             red_r, red_nxt;
  logic [RW-1:0]             tpk_r, tpk_nxt;
  logic [RCNT_W-1:0]         rcnt_r, rcnt_nxt;
  logic [TERM_W-1:0]         tmag_r, tmag_nxt;
  logic [X2_W-1:0]           x2_r, x2_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic [I_W-1:0]            i_r, i_nxt;
  logic [THR_W-1:0]          thr_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [SINE_W-1:0]         out_sine_r, out_sine_nxt;

  logic [ANGLE_WIDTH-1:0]    mag;
  logic [TP_W-1:0]           rem;
  logic [DF_W-1:0]           d_full;
  logic [TERM_W-1:0]         tnew;
  logic signed [ACC_W-1:0]   term_ext, r_ext;
  logic                      tneg, fin;
  logic [ACC_W-1:0]          amag;
  logic [QR_W-1:0]           qr;

  logic                      mul_start, mul_done;
  logic [MUL_W-1:0]          mul_a, mul_b;
  logic [MRES_W-1:0]         mul_res;
  logic                      div_start, div_done;
  logic [DIVN_W-1:0]         div_num, div_quo;

  stsin_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  stsin_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (D_W'(d_full)),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    mag      = in_angle[ANGLE_WIDTH-1] ? (~in_angle + 1'b1) : in_angle;
    rem      = red_r[TP_W-1:0];
    d_full   = {i_r, 1'b0} * {i_r, 1'b1};
    div_num  = mul_res + DIVN_W'(d_full >> 1);
    tnew     = div_quo[TERM_W-1:0];
    term_ext = $signed({{(ACC_W-TERM_W){1'b0}}, tnew});
    r_ext    = $signed({{(ACC_W-TP_W){1'b0}}, rem});
    tneg     = xneg_r ^ i_r[0];
    fin      = (tnew < {{(TERM_W-THR_W){1'b0}}, thr_r}) ||
               (i_r == I_W'(MAX_TERMS - 1));
    amag     = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    qr       = QR_W'(amag[ACC_W-1:ROUND_SHIFT]) + QR_W'(amag[ROUND_SHIFT-1]);
  end

  always_comb begin
    state_nxt     = state_r;
    xneg_nxt      = xneg_r;
    red_nxt       = red_r;
    tpk_nxt       = tpk_r;
    rcnt_nxt      = rcnt_r;
    tmag_nxt      = tmag_r;
    x2_nxt        = x2_r;
    acc_nxt       = acc_r;
    i_nxt         = i_r;
    out_valid_nxt = 1'b0;
    out_sine_nxt  = out_sine_r;
    mul_start     = 1'b0;
    mul_a         = tmag_r;
    mul_b         = MUL_W'(x2_r);
    div_start     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          xneg_nxt  = in_angle[ANGLE_WIDTH-1];
          red_nxt   = RW'({mag, {RED_SHIFT{1'b0}}});
          tpk_nxt   = TP_TOP;
          rcnt_nxt  = RCNT_W'(K_STEPS);
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (red_r >= tpk_r) begin
          red_nxt = red_r - tpk_r;
        end
        tpk_nxt  = tpk_r >> 1;
        rcnt_nxt = rcnt_r - 1'b1;
        if (rcnt_r == RCNT_W'(1)) begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        tmag_nxt  = TERM_W'(rem);
        acc_nxt   = xneg_r ? -r_ext : r_ext;
        i_nxt     = I_W'(1);
        mul_start = 1'b1;
        mul_a     = MUL_W'(rem);
        mul_b     = MUL_W'(rem);
        state_nxt = S_SQ;
      end
      S_SQ: begin
        if (mul_done) begin
          x2_nxt    = mul_res[X2_W-1:0];
          mul_start = 1'b1;
          mul_a     = tmag_r;
          mul_b     = MUL_W'(mul_res[X2_W-1:0]);
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          tmag_nxt = tnew;
          acc_nxt  = tneg ? (acc_r - term_ext) : (acc_r + term_ext);
          if (fin) begin
            state_nxt = S_OUT;
          end else begin
            i_nxt     = i_r + 1'b1;
            mul_start = 1'b1;
            mul_a     = tnew;
            state_nxt = S_MUL;
          end
        end
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        if (acc_r[ACC_W-1]) begin
          out_sine_nxt = (qr > QR_W'(SINE_MIN)) ? SINE_MIN : (~qr[SINE_W-1:0] + 1'b1);
        end else begin
          out_sine_nxt = (qr > QR_W'(SINE_MAX)) ? SINE_MAX : qr[SINE_W-1:0];
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      thr_r       <= THR_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    xneg_r     <= xneg_nxt;
    red_r      <= red_nxt;
    tpk_r      <= tpk_nxt;
    rcnt_r     <= rcnt_nxt;
    tmag_r     <= tmag_nxt;
    x2_r       <= x2_nxt;
    acc_r      <= acc_nxt;
    i_r        <= i_nxt;
    out_sine_r <= out_sine_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_sine  = $signed(out_sine_r);

endmodule

@@ rtl/stsin_chk.sv @@
// ----------------------------------------------------------------------------
// stsin_chk
// Port-level checks of the sine block, bound to the top level.
// ----------------------------------------------------------------------------
`include "sine_taylor_series_defines.svh"

module stsin_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  `STSIN_ASSERT(a_busy_after_start, start && !busy |=> busy, "accepted beat left block idle")
  `STSIN_ASSERT(a_strobe_single, out_valid |=> !out_valid, "result strobe longer than one cycle")
  `STSIN_ASSERT(a_strobe_idle, out_valid |-> !busy, "result strobe while still busy")
  `STSIN_ASSERT(a_strobe_ends_work, out_valid |-> $past(busy), "result without work before it")
  `STSIN_ASSERT_RST(a_reset_idle, !rst_n |=> !busy && !out_valid, "not idle after reset")

endmodule

bind sine_taylor_series stsin_chk u_stsin_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
